// ===== rtl/olag_pkg.sv =====
package olag_pkg;

    // Field widths of the stream payloads.
    localparam int CMD_W        = 2;
    localparam int ID_W         = 64;
    localparam int LABEL_W      = 3;
    localparam int POS_W        = 32;
    localparam int GATE_W       = 24;
    localparam int CNT16_W      = 16;
    localparam int PHYS_TOTAL_W = 7;

    // Derived arithmetic widths.
    localparam int DIFF_W = POS_W + 1;
    localparam int THR_W  = 2 * GATE_W;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_FIELDS_W = 2 * ID_W + LABEL_W + 2 * POS_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 3 + PHYS_TOTAL_W + 3 * CNT16_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration register indexes (byte address bit 2).
    localparam logic REG_GATE_DISTANCE = 1'b0;
    localparam logic REG_REQUIRE_CLASS = 1'b1;

    // Command codes carried on the input tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    // Operation class assigned by the front end.
    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_LOAD,
        OP_SCAN,
        OP_COUNT,
        OP_NOP
    } op_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN
    } back_state_t;

    // One object, as stored in the physical table.
    typedef struct packed {
        logic [ID_W-1:0]    id_high;
        logic [ID_W-1:0]    id_low;
        logic [LABEL_W-1:0] label;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
    } phys_entry_t;

    // A classified beat waiting in the queue.
    typedef struct packed {
        op_t         op;
        phys_entry_t entry;
    } front_item_t;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic        valid;
        front_item_t item;
    } queue_head_t;

    // Result beat; append sits in the lowest bit.
    typedef struct packed {
        logic [CNT16_W-1:0]      unmatched_total;
        logic [CNT16_W-1:0]      matched_total;
        logic [CNT16_W-1:0]      virtual_total;
        logic [PHYS_TOTAL_W-1:0] physical_total;
        logic                    table_overflow;
        logic                    matched;
        logic                    append;
    } result_t;

endpackage

// ===== rtl/olag_front.sv =====
module olag_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0 up: id_high, id_low, class_label, pos_x, pos_y, zero fill.
    input  logic [olag_pkg::S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0 up: cmd.
    input  logic [olag_pkg::CMD_W-1:0]     s_tuser,
    input  logic                          gate_zero,
    output olag_pkg::queue_head_t         head,
    input  logic                          pop
);
    import olag_pkg::*;

    front_item_t item_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push;
    front_item_t new_item;

    // Unpack the beat and classify the command.
    always_comb begin
        new_item.entry.id_high = s_tdata[ID_W-1:0];
        new_item.entry.id_low  = s_tdata[2*ID_W-1:ID_W];
        new_item.entry.label   = s_tdata[2*ID_W+LABEL_W-1:2*ID_W];
        new_item.entry.x       = s_tdata[2*ID_W+LABEL_W+POS_W-1:2*ID_W+LABEL_W];
        new_item.entry.y       = s_tdata[2*ID_W+LABEL_W+2*POS_W-1:2*ID_W+LABEL_W+POS_W];
        case (cmd_t'(s_tuser))
            CMD_CLEAR: begin
                new_item.op = OP_CLEAR;
            end
            CMD_LOAD: begin
                new_item.op = OP_LOAD;
            end
            CMD_QUERY: begin
                // With a zero gate a query only counts and never scans the table.
                new_item.op = gate_zero ? OP_COUNT : OP_SCAN;
            end
            default: begin
                new_item.op = OP_NOP;
            end
        endcase
    end

    // Two-entry queue toward the back end.
    assign s_tready = (fill_reg != 2'd2);
    assign push     = s_tvalid && s_tready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            item_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign head.valid = (fill_reg != 2'd0);
    assign head.item  = item_reg[rd_ptr_reg];

endmodule

// ===== rtl/olag_back.sv =====
module olag_back #(
    parameter int MAX_PHYSICAL = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [olag_pkg::GATE_W-1:0]    gate_distance,
    input  logic                          require_class_match,
    input  olag_pkg::queue_head_t         head,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0 up: append, matched, table_overflow, physical_total,
    // virtual_total, matched_total, unmatched_total, zero fill.
    output logic [olag_pkg::M_TDATA_W-1:0] m_tdata
);
    import olag_pkg::*;

    localparam int AW = (MAX_PHYSICAL > 1) ? $clog2(MAX_PHYSICAL) : 1;
    localparam int CW = $clog2(MAX_PHYSICAL + 1);

    function automatic logic [CNT16_W-1:0] sat_inc(input logic [CNT16_W-1:0] v);
        return (v == '1) ? v : v + CNT16_W'(1);
    endfunction

    // Physical object table.
    phys_entry_t mem [MAX_PHYSICAL];
    phys_entry_t rd_data_reg;

    back_state_t state_reg, state_next;

    logic [CW-1:0]      count_reg, count_next;
    logic [CNT16_W-1:0] vcnt_reg, vcnt_next;
    logic [CNT16_W-1:0] mcnt_reg, mcnt_next;
    logic [CNT16_W-1:0] ucnt_reg, ucnt_next;
    logic [CW-1:0]      scan_idx_reg;
    phys_entry_t        query_reg;
    logic [THR_W-1:0]   thr_reg;
    logic               hit_reg;
    logic [3:0]         vld_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg;
    result_t            res;

    logic out_free, exec_now, start_scan, issue, finish, mem_we, load_out;
    logic [CW+PHYS_TOTAL_W-1:0] ptot_wide;

    // Comparison pipeline registers.
    logic signed [DIFF_W-1:0] dx_a_reg, dy_a_reg;
    logic                     id_eq_a_reg, lbl_ok_a_reg;
    logic [POS_W-1:0]         adx_b_reg, ady_b_reg;
    logic                     id_eq_b_reg, lbl_ok_b_reg;
    logic [THR_W-1:0]         sqx_c_reg, sqy_c_reg;
    logic                     in_box_c_reg, id_eq_c_reg, lbl_ok_c_reg;
    logic [THR_W:0]           sum_d;
    logic                     hit_d;

    assign out_free = !out_valid_reg || m_tready;

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (head.valid && out_free && head.item.op == OP_SCAN) begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (scan_idx_reg == count_reg) begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                if (vld_reg == '0 && out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        pop        = 1'b0;
        exec_now   = 1'b0;
        start_scan = 1'b0;
        issue      = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (head.valid && out_free) begin
                    pop = 1'b1;
                    if (head.item.op == OP_SCAN) begin
                        start_scan = 1'b1;
                    end else begin
                        exec_now = 1'b1;
                    end
                end
            end
            BK_SCAN: begin
                issue = (scan_idx_reg != count_reg);
            end
            BK_DRAIN: begin
                finish = (vld_reg == '0) && out_free;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    // Counter updates and the result beat.
    always_comb begin
        count_next = count_reg;
        vcnt_next  = vcnt_reg;
        mcnt_next  = mcnt_reg;
        ucnt_next  = ucnt_reg;
        mem_we     = 1'b0;
        res        = '0;
        if (exec_now) begin
            case (head.item.op)
                OP_CLEAR: begin
                    count_next = '0;
                    vcnt_next  = '0;
                    mcnt_next  = '0;
                    ucnt_next  = '0;
                end
                OP_LOAD: begin
                    if (count_reg >= CW'(MAX_PHYSICAL)) begin
                        res.table_overflow = 1'b1;
                    end else begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_COUNT: begin
                    vcnt_next = sat_inc(vcnt_reg);
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end else if (finish) begin
            vcnt_next = sat_inc(vcnt_reg);
            if (hit_reg) begin
                res.matched = 1'b1;
                mcnt_next   = sat_inc(mcnt_reg);
            end else begin
                res.append = 1'b1;
                ucnt_next  = sat_inc(ucnt_reg);
            end
        end
        ptot_wide           = {{PHYS_TOTAL_W{1'b0}}, count_next};
        res.physical_total  = ptot_wide[PHYS_TOTAL_W-1:0];
        res.virtual_total   = vcnt_next;
        res.matched_total   = mcnt_next;
        res.unmatched_total = ucnt_next;
    end

    assign load_out = exec_now || finish;

    // Output register: holds the beat until the consumer takes it.
    always_comb begin
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            vcnt_reg      <= '0;
            mcnt_reg      <= '0;
            ucnt_reg      <= '0;
            scan_idx_reg  <= '0;
            vld_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            vcnt_reg      <= vcnt_next;
            mcnt_reg      <= mcnt_next;
            ucnt_reg      <= ucnt_next;
            vld_reg       <= {vld_reg[2:0], issue};
            out_valid_reg <= out_valid_next;
            if (start_scan) begin
                scan_idx_reg <= '0;
                hit_reg      <= 1'b0;
            end else begin
                if (issue) begin
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                end
                if (vld_reg[3] && hit_d) begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    // Query latch and squared gate.
    always_ff @(posedge aclk) begin
        if (start_scan) begin
            query_reg <= head.item.entry;
            thr_reg   <= THR_W'(gate_distance) * THR_W'(gate_distance);
        end
        if (load_out) begin
            out_data_reg <= res;
        end
    end

    // Table write on load and registered read during the scan.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[count_reg[AW-1:0]] <= head.item.entry;
        end
        if (issue) begin
            rd_data_reg <= mem[scan_idx_reg[AW-1:0]];
        end
    end

    // Stage A: coordinate differences, id and label compares.
    always_ff @(posedge aclk) begin
        dx_a_reg     <= $signed({rd_data_reg.x[POS_W-1], rd_data_reg.x})
                      - $signed({query_reg.x[POS_W-1], query_reg.x});
        dy_a_reg     <= $signed({rd_data_reg.y[POS_W-1], rd_data_reg.y})
                      - $signed({query_reg.y[POS_W-1], query_reg.y});
        id_eq_a_reg  <= (rd_data_reg.id_high == query_reg.id_high)
                     && (rd_data_reg.id_low == query_reg.id_low);
        lbl_ok_a_reg <= !require_class_match || (rd_data_reg.label == query_reg.label);
    end

    // Stage B: magnitudes; they always fit in 32 bits.
    always_ff @(posedge aclk) begin
        adx_b_reg    <= dx_a_reg[DIFF_W-1] ? POS_W'(-dx_a_reg) : POS_W'(dx_a_reg);
        ady_b_reg    <= dy_a_reg[DIFF_W-1] ? POS_W'(-dy_a_reg) : POS_W'(dy_a_reg);
        id_eq_b_reg  <= id_eq_a_reg;
        lbl_ok_b_reg <= lbl_ok_a_reg;
    end

    // Stage C: box test against the gate and squares of the low 24 bits, which
    // are exact whenever the box test passes.
    always_ff @(posedge aclk) begin
        in_box_c_reg <= (adx_b_reg <= POS_W'(gate_distance))
                     && (ady_b_reg <= POS_W'(gate_distance));
        sqx_c_reg    <= THR_W'(adx_b_reg[GATE_W-1:0]) * THR_W'(adx_b_reg[GATE_W-1:0]);
        sqy_c_reg    <= THR_W'(ady_b_reg[GATE_W-1:0]) * THR_W'(ady_b_reg[GATE_W-1:0]);
        id_eq_c_reg  <= id_eq_b_reg;
        lbl_ok_c_reg <= lbl_ok_b_reg;
    end

    // Stage D: an id match wins outright, else the labeled distance test.
    assign sum_d = {1'b0, sqx_c_reg} + {1'b0, sqy_c_reg};
    assign hit_d = id_eq_c_reg
                || (lbl_ok_c_reg && in_box_c_reg && (sum_d <= {1'b0, thr_reg}));

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, out_data_reg};

endmodule

// ===== rtl/object_list_association_gate.sv =====
// Object list association gate. Send a clear command at the start of each frame, then
// the frame's physical objects as load beats, then one query beat per virtual object;
// every input beat yields exactly one result beat carrying the match flags and the
// frame counters after that beat. Clear, load, unused commands and queries with a
// zero gate distance are executed straight from the queue head in the back end. A
// query with a nonzero gate scans the physical table from its single-port memory,
// one entry per cycle; that scan sets the query rate. A two-beat queue accepts
// further input while a scan runs, and the output register holds each result until
// the consumer takes it; the back end starts no new beat while a result waits untaken.
// The gate distance and class-match registers sit at byte addresses 0 and 4 and must
// only be written while no beats are in flight. The table is not cleared after
// reset; only entries loaded in the current frame are ever read.
module object_list_association_gate #(
    parameter int MAX_PHYSICAL = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0 up: id_high, id_low, class_label, pos_x, pos_y, zero fill.
    input  logic [olag_pkg::S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0 up: cmd.
    input  logic [olag_pkg::CMD_W-1:0]     s_tuser,
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0 up: append, matched, table_overflow, physical_total,
    // virtual_total, matched_total, unmatched_total, zero fill.
    output logic [olag_pkg::M_TDATA_W-1:0] m_tdata,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import olag_pkg::*;

    logic [GATE_W-1:0] gate_reg;
    logic              rcm_reg;
    logic              cfg_write;
    queue_head_t       head;
    logic              pop;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_reg <= '0;
            rcm_reg  <= 1'b0;
        end else if (cfg_write) begin
            if (paddr[2] == REG_GATE_DISTANCE) begin
                gate_reg <= pwdata[GATE_W-1:0];
            end else begin
                rcm_reg <= pwdata[0];
            end
        end
    end

    // Register readback.
    always_comb begin
        if (paddr[2] == REG_REQUIRE_CLASS) begin
            prdata = {31'b0, rcm_reg};
        end else begin
            prdata = {{(32 - GATE_W){1'b0}}, gate_reg};
        end
    end

    olag_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .gate_zero (gate_reg == '0),
        .head      (head),
        .pop       (pop)
    );

    olag_back #(
        .MAX_PHYSICAL (MAX_PHYSICAL)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .gate_distance       (gate_reg),
        .require_class_match (rcm_reg),
        .head                (head),
        .pop                 (pop),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata)
    );

endmodule
